// ----- rtl/cbsp_pkg.sv -----
package cbsp_pkg;

  // Stream constants
  localparam logic [31:0] BagMagic       = 32'hB5EE9C72;
  localparam int unsigned IndexFlagBit   = 7;
  localparam logic [7:0]  RefSizeMask    = 8'h07;
  localparam logic [31:0] MaxCellsReset  = 32'd100000;
  localparam logic [3:0]  MaxOffsetWidth = 4'd8;
  localparam logic [2:0]  MaxRefWidth    = 3'd4;
  localparam logic [3:0]  MagicWidth     = 4'd4;
  localparam int unsigned QueueDepth     = 4;

  typedef enum logic [3:0] {
    PH_MAGIC    = 4'd0,
    PH_FLAGS    = 4'd1,
    PH_OFFSZ    = 4'd2,
    PH_CELLS    = 4'd3,
    PH_ROOTS    = 4'd4,
    PH_ABSENT   = 4'd5,
    PH_TOTSZ    = 4'd6,
    PH_ROOTLIST = 4'd7,
    PH_SKIP     = 4'd8,
    PH_D1       = 4'd9,
    PH_D2       = 4'd10,
    PH_DATA     = 4'd11,
    PH_REFS     = 4'd12,
    PH_DONE     = 4'd13,
    PH_ERROR    = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_ROOT   = 3'd1,
    KIND_DESC   = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_REF    = 3'd4,
    KIND_DONE   = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_REF_SIZE = 3'd2,
    ERR_OFF_SIZE = 3'd3,
    ERR_COUNT    = 3'd4,
    ERR_BAD_REF  = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] cell_idx;
    logic [31:0] value;
    logic [7:0]  desc1;
    logic [7:0]  desc2;
    err_e        err;
  } event_t;

  // All results caused by one accepted byte
  typedef struct packed {
    event_t first;
    event_t second;
    logic   pair;
  } entry_t;

  function automatic event_t mk_event(kind_e kind, logic [31:0] cell_idx, logic [31:0] value,
                                      logic [7:0] desc1, logic [7:0] desc2, err_e err);
    event_t ev;
    ev.kind     = kind;
    ev.cell_idx = cell_idx;
    ev.value    = value;
    ev.desc1    = desc1;
    ev.desc2    = desc2;
    ev.err      = err;
    return ev;
  endfunction

endpackage

// ----- rtl/cbsp_front.sv -----
module cbsp_front
  import cbsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        end_of_stream_i,
  input  logic [31:0] max_cell_count_i,
  output logic        push_o,
  output entry_t      entry_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [31:0] facc_q, facc_d;
  logic [2:0]  ref_w_q, ref_w_d;
  logic [3:0]  off_w_q, off_w_d;
  logic        idx_q, idx_d;
  logic [31:0] total_q, total_d;
  logic [31:0] roots_q, roots_d;
  logic [35:0] skip_q, skip_d;
  logic [31:0] cur_q, cur_d;
  logic [7:0]  data_q, data_d;
  logic [2:0]  refs_q, refs_d;
  logic [7:0]  hold_q, hold_d;
  logic        root_seen_q, root_seen_d;

  logic [31:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic [3:0]  fld_width;
  logic        fld_done;
  logic        collecting;
  logic [35:0] skip_total;
  logic [31:0] cur_inc;
  logic [7:0]  data_len;
  event_t      ev0, ev1;
  logic        v0, v1;

  // Big-endian field collection
  assign acc_shift = {facc_q[23:0], stream_byte_i};
  assign cnt_inc   = fcnt_q + 4'd1;
  assign fld_done  = (cnt_inc >= fld_width);
  assign cur_inc   = cur_q + 32'd1;
  assign data_len  = {1'b0, stream_byte_i[7:1]} + {7'd0, stream_byte_i[0]};
  assign skip_total = total_q * {32'd0, off_w_q};

  always_comb begin
    fld_width  = {1'b0, ref_w_q};
    collecting = 1'b0;
    unique case (phase_q)
      PH_MAGIC: begin
        fld_width  = MagicWidth;
        collecting = 1'b1;
      end
      PH_TOTSZ: begin
        fld_width  = off_w_q;
        collecting = 1'b1;
      end
      PH_CELLS, PH_ROOTS, PH_ABSENT, PH_ROOTLIST, PH_REFS: begin
        collecting = 1'b1;
      end
      default: begin
        collecting = 1'b0;
      end
    endcase
  end

  // Parse one byte
  always_comb begin
    phase_d     = phase_q;
    fcnt_d      = fcnt_q;
    facc_d      = facc_q;
    ref_w_d     = ref_w_q;
    off_w_d     = off_w_q;
    idx_d       = idx_q;
    total_d     = total_q;
    roots_d     = roots_q;
    skip_d      = skip_q;
    cur_d       = cur_q;
    data_d      = data_q;
    refs_d      = refs_q;
    hold_d      = hold_q;
    root_seen_d = root_seen_q;
    ev0         = '0;
    ev1         = '0;
    v0          = 1'b0;
    v1          = 1'b0;

    if (take_i) begin
      if (collecting) begin
        if (fld_done) begin
          facc_d = '0;
          fcnt_d = '0;
        end else begin
          facc_d = acc_shift;
          fcnt_d = cnt_inc;
        end
      end

      unique case (phase_q)
        PH_MAGIC: begin
          if (fld_done) begin
            if (acc_shift != BagMagic) begin
              ev0     = mk_event(KIND_ERROR, cur_q, '0, '0, '0, ERR_MAGIC);
              v0      = 1'b1;
              phase_d = PH_ERROR;
            end else begin
              phase_d = PH_FLAGS;
            end
          end
        end
        PH_FLAGS: begin
          idx_d   = stream_byte_i[IndexFlagBit];
          ref_w_d = stream_byte_i[2:0] & RefSizeMask[2:0];
          if (stream_byte_i[2:0] == 3'd0 || stream_byte_i[2:0] > MaxRefWidth) begin
            ev0     = mk_event(KIND_ERROR, cur_q, '0, '0, '0, ERR_REF_SIZE);
            v0      = 1'b1;
            phase_d = PH_ERROR;
          end else begin
            phase_d = PH_OFFSZ;
          end
        end
        PH_OFFSZ: begin
          if (stream_byte_i == 8'd0 || stream_byte_i > {4'd0, MaxOffsetWidth}) begin
            ev0     = mk_event(KIND_ERROR, cur_q, '0, '0, '0, ERR_OFF_SIZE);
            v0      = 1'b1;
            phase_d = PH_ERROR;
          end else begin
            off_w_d = stream_byte_i[3:0];
            phase_d = PH_CELLS;
          end
        end
        PH_CELLS: begin
          if (fld_done) begin
            total_d = acc_shift;
            phase_d = PH_ROOTS;
          end
        end
        PH_ROOTS: begin
          if (fld_done) begin
            roots_d = acc_shift;
            phase_d = PH_ABSENT;
          end
        end
        PH_ABSENT: begin
          if (fld_done) begin
            phase_d = PH_TOTSZ;
          end
        end
        PH_TOTSZ: begin
          if (fld_done) begin
            if (total_q == 32'd0 || total_q > max_cell_count_i) begin
              ev0     = mk_event(KIND_ERROR, cur_q, '0, '0, '0, ERR_COUNT);
              v0      = 1'b1;
              phase_d = PH_ERROR;
            end else begin
              ev0 = mk_event(KIND_HEADER, '0, total_q, '0, '0, ERR_NONE);
              v0  = 1'b1;
              if (roots_q != 32'd0) begin
                phase_d = PH_ROOTLIST;
              end else if (idx_q) begin
                skip_d  = skip_total;
                phase_d = (skip_total != 36'd0) ? PH_SKIP : PH_D1;
              end else begin
                phase_d = PH_D1;
              end
            end
          end
        end
        PH_ROOTLIST: begin
          if (fld_done) begin
            if (!root_seen_q) begin
              root_seen_d = 1'b1;
              ev0         = mk_event(KIND_ROOT, '0, acc_shift, '0, '0, ERR_NONE);
              v0          = 1'b1;
            end
            roots_d = roots_q - 32'd1;
            if (roots_q == 32'd1) begin
              if (idx_q) begin
                skip_d  = skip_total;
                phase_d = (skip_total != 36'd0) ? PH_SKIP : PH_D1;
              end else begin
                phase_d = PH_D1;
              end
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 36'd1;
          if (skip_q == 36'd1) begin
            phase_d = PH_D1;
          end
        end
        PH_D1: begin
          hold_d  = stream_byte_i;
          phase_d = PH_D2;
        end
        PH_D2: begin
          ev0    = mk_event(KIND_DESC, cur_q, '0, hold_q, stream_byte_i, ERR_NONE);
          v0     = 1'b1;
          refs_d = hold_q[2:0] & RefSizeMask[2:0];
          data_d = data_len;
          if (data_len != 8'd0) begin
            phase_d = PH_DATA;
          end else if (hold_q[2:0] != 3'd0) begin
            phase_d = PH_REFS;
          end else begin
            cur_d = cur_inc;
            if (cur_inc == total_q) begin
              ev1     = mk_event(KIND_DONE, cur_inc, total_q, '0, '0, ERR_NONE);
              v1      = 1'b1;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_D1;
            end
          end
        end
        PH_DATA: begin
          ev0    = mk_event(KIND_DATA, cur_q, {24'd0, stream_byte_i}, '0, '0, ERR_NONE);
          v0     = 1'b1;
          data_d = data_q - 8'd1;
          if (data_q == 8'd1) begin
            if (refs_q != 3'd0) begin
              phase_d = PH_REFS;
            end else begin
              cur_d = cur_inc;
              if (cur_inc == total_q) begin
                ev1     = mk_event(KIND_DONE, cur_inc, total_q, '0, '0, ERR_NONE);
                v1      = 1'b1;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_D1;
              end
            end
          end
        end
        PH_REFS: begin
          if (fld_done) begin
            if (acc_shift >= total_q) begin
              ev0     = mk_event(KIND_ERROR, cur_q, '0, '0, '0, ERR_BAD_REF);
              v0      = 1'b1;
              phase_d = PH_ERROR;
            end else begin
              ev0    = mk_event(KIND_REF, cur_q, acc_shift, '0, '0, ERR_NONE);
              v0     = 1'b1;
              refs_d = refs_q - 3'd1;
              if (refs_q == 3'd1) begin
                cur_d = cur_inc;
                if (cur_inc == total_q) begin
                  ev1     = mk_event(KIND_DONE, cur_inc, total_q, '0, '0, ERR_NONE);
                  v1      = 1'b1;
                  phase_d = PH_DONE;
                end else begin
                  phase_d = PH_D1;
                end
              end
            end
          end
        end
        default: begin
          // done or error: drop bytes until end of stream
        end
      endcase

      // Flag truncation, then restart for the next bag
      if (end_of_stream_i) begin
        if (phase_d != PH_DONE && phase_d != PH_ERROR) begin
          if (v0) begin
            ev1 = mk_event(KIND_ERROR, cur_d, '0, '0, '0, ERR_TRUNC);
            v1  = 1'b1;
          end else begin
            ev0 = mk_event(KIND_ERROR, cur_d, '0, '0, '0, ERR_TRUNC);
            v0  = 1'b1;
          end
        end
        phase_d     = PH_MAGIC;
        fcnt_d      = '0;
        facc_d      = '0;
        ref_w_d     = '0;
        off_w_d     = '0;
        idx_d       = 1'b0;
        total_d     = '0;
        roots_d     = '0;
        skip_d      = '0;
        cur_d       = '0;
        data_d      = '0;
        refs_d      = '0;
        hold_d      = '0;
        root_seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      fcnt_q      <= '0;
      facc_q      <= '0;
      ref_w_q     <= '0;
      off_w_q     <= '0;
      idx_q       <= 1'b0;
      total_q     <= '0;
      roots_q     <= '0;
      skip_q      <= '0;
      cur_q       <= '0;
      data_q      <= '0;
      refs_q      <= '0;
      hold_q      <= '0;
      root_seen_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fcnt_q      <= fcnt_d;
      facc_q      <= facc_d;
      ref_w_q     <= ref_w_d;
      off_w_q     <= off_w_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      roots_q     <= roots_d;
      skip_q      <= skip_d;
      cur_q       <= cur_d;
      data_q      <= data_d;
      refs_q      <= refs_d;
      hold_q      <= hold_d;
      root_seen_q <= root_seen_d;
    end
  end

  // Hand the byte's results to the queue
  assign push_o         = take_i && v0;
  assign entry_o.first  = ev0;
  assign entry_o.second = ev1;
  assign entry_o.pair   = v1;

endmodule

// ----- rtl/cbsp_queue.sv -----
module cbsp_queue
  import cbsp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   ready_o,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = store_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Write the entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/cbsp_back.sv -----
module cbsp_back
  import cbsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [31:0] cell_number_o,
  output logic [31:0] event_value_o,
  output logic [7:0]  first_descriptor_o,
  output logic [7:0]  second_descriptor_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  logic   sel_q, sel_d;
  logic   fire;
  event_t ev;

  assign fire        = q_valid_i && out_ready_i;
  assign out_valid_o = q_valid_i;
  assign ev          = sel_q ? entry_i.second : entry_i.first;

  // Step through the one or two results of the head entry
  always_comb begin
    sel_d = sel_q;
    pop_o = 1'b0;
    if (fire) begin
      if (entry_i.pair && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  assign event_kind_o        = ev.kind;
  assign cell_number_o       = ev.cell_idx;
  assign event_value_o       = ev.value;
  assign first_descriptor_o  = ev.desc1;
  assign second_descriptor_o = ev.desc2;
  assign error_code_o        = ev.err;
  assign last_of_run_o       = !entry_i.pair || sel_q;

endmodule

// ----- rtl/cell_bag_stream_parser_unit.sv -----
// Bag-of-cells stream parser. Takes one byte per cycle while the queue has room:
// a parser checks the magic, flags and header counts, reports the first root, skips
// the index and walks the cells, writing the zero, one or two results of each byte
// into a 4-entry queue (Depth). An output stage drains that queue one result per
// cycle while out_ready is high, so a result shows up in the cycle after its byte at
// the earliest. Bytes that cause two results (descriptors or last record followed by
// done, or any result followed by a truncation error) hold the output for two results;
// under a steady run of such bytes the input stalls once the queue fills.
// max_cell_count resets to 100000 and may be rewritten only while the block is idle.
module cell_bag_stream_parser_unit
  import cbsp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [31:0] cell_number_o,
  output logic [31:0] event_value_o,
  output logic [7:0]  first_descriptor_o,
  output logic [7:0]  second_descriptor_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  logic [31:0] max_cells_q;
  logic        take;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  logic        q_valid;
  logic        q_ready;
  entry_t      head_entry;

  // Hold the cell count limit
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cells_q <= MaxCellsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_cells_q <= cfg_data_i;
    end
  end

  assign in_ready_o = q_ready;
  assign take       = in_valid_i && in_ready_o;

  cbsp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .stream_byte_i    (stream_byte_i),
    .end_of_stream_i  (end_of_stream_i),
    .max_cell_count_i (max_cells_q),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  cbsp_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  cbsp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .entry_i             (head_entry),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .event_kind_o        (event_kind_o),
    .cell_number_o       (cell_number_o),
    .event_value_o       (event_value_o),
    .first_descriptor_o  (first_descriptor_o),
    .second_descriptor_o (second_descriptor_o),
    .error_code_o        (error_code_o),
    .last_of_run_o       (last_of_run_o)
  );

endmodule

// ----- rtl/cbsp_checker.sv -----
module cbsp_checker
  import cbsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  stream_byte_i,
  input logic        end_of_stream_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_kind_o,
  input logic [31:0] cell_number_o,
  input logic [31:0] event_value_o,
  input logic [7:0]  first_descriptor_o,
  input logic [7:0]  second_descriptor_o,
  input logic [2:0]  error_code_o,
  input logic        last_of_run_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(cell_number_o) && $stable(event_value_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // Error code is set exactly on error results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match result kind");

  // Done closes its run and reports the cell count twice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == KIND_DONE |->
      last_of_run_o && cell_number_o == event_value_o)
    else $error("malformed done result");

  // Descriptor bytes only travel with descriptor results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != KIND_DESC |->
      first_descriptor_o == 8'd0 && second_descriptor_o == 8'd0)
    else $error("descriptor bytes on a non-descriptor result");

  // A run that is not closed continues in the next result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("run left open");

endmodule

bind cell_bag_stream_parser_unit cbsp_checker u_cbsp_checker (.*);
